// File: src/cng_pkg.sv
// Shared constants and types of the character n-gram splitter
`default_nettype none
package cng_pkg;

  localparam int MAX_TOKEN_CHARS_DEF = 10;
  localparam int MAX_DOC_BYTES_DEF   = 65536;

  localparam int LEN_W  = 3;
  localparam int TSZ_W  = 4;
  localparam int OFS_W  = 16;
  localparam int NLEN_W = 7;
  localparam int NLEN_MAX = 127;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_TOK_CHARS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMIT_SHORT = 1'd1;

  localparam logic [TSZ_W-1:0] TOK_CHARS_RST  = 4'd2;
  localparam logic             EMIT_SHORT_RST = 1'b0;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic              doc_done;
    logic              is_short;
    logic [NLEN_W-1:0] ngram_len;
    logic [OFS_W-1:0]  ngram_offset;
  } result_t;

endpackage
`default_nettype wire

// File: src/cng_cell.sv
// One window cell: holds the byte length of one character
`default_nettype none
module cng_cell (
  input  wire                          clk,
  input  wire                          en,
  input  wire cng_pkg::cell_ctrl_t     ctrl,
  input  wire [cng_pkg::LEN_W-1:0]     new_len,
  input  wire [cng_pkg::LEN_W-1:0]     right_len,
  output logic [cng_pkg::LEN_W-1:0]    len_q
);
  import cng_pkg::*;

  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;

  always_comb begin
    len_nxt = len_r;
    if (ctrl.load) begin
      len_nxt = new_len;
    end else if (ctrl.shift) begin
      len_nxt = right_len;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r <= len_nxt;
    end
  end

  assign len_q = len_r;

endmodule
`default_nettype wire

// File: src/cng_skid.sv
// Output register with skid stage for result words
`default_nettype none
module cng_skid (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  wire cng_pkg::result_t  push_res,
  output logic                   can_push,
  output logic                   out_valid,
  input  wire                    out_ready,
  output cng_pkg::result_t       out_res
);
  import cng_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_res_r, out_res_nxt;
  result_t skid_res_r, skid_res_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_res_nxt    = skid_res_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_res_nxt   = push_res;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      skid_res_nxt   = push_res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
`default_nettype wire

// File: src/character_ngram_splitter.sv
// Character n-gram splitter: window of character lengths emitting byte spans
// A result word is registered in the output stage of cng_skid, or in its skid stage while
// out_tready is low, before it appears on out_tvalid. Throughput: one input word per cycle
// while the skid stage is empty; it lets input continue while one result waits on out_tready.
// Reset (rst_n low, synchronous): token size 2, emit_short = 0, window empty.
// Window cells hold no reset; only cells below the count are ever read.
`default_nettype none
module character_ngram_splitter #(
  parameter int MAX_TOKEN_CHARS = cng_pkg::MAX_TOKEN_CHARS_DEF,
  parameter int MAX_DOC_BYTES   = cng_pkg::MAX_DOC_BYTES_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [cng_pkg::IN_DATA_W-1:0]     in_tdata,   // [2:0] char_bytes, [7:3] zero
  input  wire                              in_tlast,   // last_char
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [cng_pkg::OUT_DATA_W-1:0]   out_tdata,  // [15:0] ngram_offset, [22:16] ngram_len
  output logic                             out_tuser,  // is_short
  output logic                             out_tlast,  // doc_done
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [cng_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [cng_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cng_pkg::*;

  localparam int CNT_W   = $clog2(MAX_TOKEN_CHARS + 1);
  localparam int BYT_W   = $clog2(MAX_TOKEN_CHARS * 7 + 1);
  localparam int OFS_CAP = (MAX_DOC_BYTES - 1 > 65535) ? 65535 : MAX_DOC_BYTES - 1;

  logic [TSZ_W-1:0] tok_chars_r;
  logic             emit_short_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [BYT_W-1:0] bytes_r, bytes_nxt;
  logic [OFS_W-1:0] start_r, start_nxt;
  logic             any_r, any_nxt;
  logic             broken_r, broken_nxt;

  logic [LEN_W-1:0] cell_len [MAX_TOKEN_CHARS];
  cell_ctrl_t       cell_ctrl [MAX_TOKEN_CHARS];

  logic             in_fire;
  logic [LEN_W-1:0] clen;
  logic [CNT_W-1:0] tsz;
  logic             append, emit, short_emit;
  logic [CNT_W-1:0] cnt_app;
  logic [BYT_W-1:0] bytes_app;
  logic [LEN_W-1:0] first_len;
  logic [OFS_W:0]   pos;
  logic [NLEN_W-1:0] len_sat;
  logic             push, can_push;
  result_t          push_res, out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_chars_r  <= TOK_CHARS_RST;
      emit_short_r <= EMIT_SHORT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TOK_CHARS:  tok_chars_r  <= cfg_data[TSZ_W-1:0];
        CFG_EMIT_SHORT: emit_short_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_tready = can_push;
  assign in_fire   = in_tvalid && can_push;
  assign clen      = in_tdata[LEN_W-1:0];

  always_comb begin
    if (tok_chars_r == '0) begin
      tsz = CNT_W'(1);
    end else if (int'(tok_chars_r) > MAX_TOKEN_CHARS) begin
      tsz = CNT_W'(MAX_TOKEN_CHARS);
    end else begin
      tsz = CNT_W'(tok_chars_r);
    end
  end

  always_comb begin
    append    = !broken_r && (clen != '0) && (int'(count_r) < MAX_TOKEN_CHARS);
    cnt_app   = count_r + CNT_W'(append);
    bytes_app = bytes_r + (append ? BYT_W'(clen) : BYT_W'(0));
    emit      = append && (cnt_app >= tsz);
    first_len = (count_r == '0) ? clen : cell_len[0];
    pos       = {1'b0, start_r} + (OFS_W + 1)'(first_len);
    len_sat   = (32'(bytes_app) > NLEN_MAX) ? NLEN_W'(NLEN_MAX) : NLEN_W'(bytes_app);
    short_emit = in_tlast && !emit && emit_short_r && (cnt_app != '0) && !any_r;
  end

  always_comb begin
    count_nxt  = emit ? count_r : cnt_app;
    bytes_nxt  = emit ? (bytes_app - BYT_W'(first_len)) : bytes_app;
    start_nxt  = start_r;
    if (emit) begin
      start_nxt = (int'(pos) > OFS_CAP) ? OFS_W'(OFS_CAP) : pos[OFS_W-1:0];
    end
    any_nxt    = any_r || emit;
    broken_nxt = broken_r || (clen == '0);
    if (in_tlast) begin
      count_nxt  = '0;
      bytes_nxt  = '0;
      start_nxt  = '0;
      any_nxt    = 1'b0;
      broken_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      bytes_r  <= '0;
      start_r  <= '0;
      any_r    <= 1'b0;
      broken_r <= 1'b0;
    end else if (in_fire) begin
      count_r  <= count_nxt;
      bytes_r  <= bytes_nxt;
      start_r  <= start_nxt;
      any_r    <= any_nxt;
      broken_r <= broken_nxt;
    end
  end

  // new length lands at count, or one below when the window drops its head
  for (genvar i = 0; i < MAX_TOKEN_CHARS; i++) begin : g_cell
    logic [LEN_W-1:0] right_len;
    if (i == MAX_TOKEN_CHARS - 1) begin : g_end
      assign right_len = '0;
    end else begin : g_mid
      assign right_len = cell_len[i+1];
    end

    always_comb begin
      cell_ctrl[i].shift = emit;
      cell_ctrl[i].load  = append &&
                           ((emit && (count_r != '0) && (count_r - CNT_W'(1) == CNT_W'(i))) ||
                            (!emit && (count_r == CNT_W'(i))));
    end

    cng_cell u_cell (
      .clk       (clk),
      .en        (in_fire),
      .ctrl      (cell_ctrl[i]),
      .new_len   (clen),
      .right_len (right_len),
      .len_q     (cell_len[i])
    );
  end

  assign push = in_fire && (emit || short_emit);

  always_comb begin
    push_res.ngram_offset = start_r;
    push_res.ngram_len    = len_sat;
    push_res.is_short     = short_emit;
    push_res.doc_done     = in_tlast;
  end

  cng_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {{(OUT_DATA_W - OFS_W - NLEN_W){1'b0}}, out_res.ngram_len,
                      out_res.ngram_offset};
  assign out_tuser = out_res.is_short;
  assign out_tlast = out_res.doc_done;

endmodule
`default_nettype wire

// File: test/character_ngram_splitter_test.sv
// Self-checking testbench of the character n-gram splitter: directed, long and random documents
`timescale 1ns / 100ps
module character_ngram_splitter_test;
  import cng_pkg::*;

  localparam int LIMIT   = 6_000_000;
  localparam int SETTLE  = 4;
  localparam int OFS_CAP = (MAX_DOC_BYTES_DEF - 1 > 65535) ? 65535 : MAX_DOC_BYTES_DEF - 1;
  localparam int LONG_WORDS = 150;

  typedef enum {ROW_WORD, ROW_CFG} row_kind_t;
  typedef enum {EXP_NONE, EXP_GIVEN, EXP_MODEL} exp_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [LEN_W-1:0]      clen;
    logic                  eod;
    exp_kind_t             ek;
    result_t               res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  wire in_tready;
  wire out_tvalid;
  wire [OUT_DATA_W-1:0] out_tdata;
  wire out_tuser;
  wire out_tlast;
  wire cfg_ready;

  character_ngram_splitter uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor copy of the block
  logic [TSZ_W-1:0] cur_tsz = TOK_CHARS_RST;
  logic             cur_short = EMIT_SHORT_RST;
  logic [LEN_W-1:0] win_len [MAX_TOKEN_CHARS_DEF];
  int unsigned win_cnt = 0, win_bytes = 0, win_start = 0;
  bit saw_ngram = 0, broken = 0;

  result_t ngram_q [$];
  row_t    plan [$];

  int errors = 0, cycles = 0, stall_left = 0;
  int words_sent = 0, docs_ended = 0, results_seen = 0, cfg_writes = 0;
  int doc_left = 0;
  bit doc_noise = 0, no_idle = 0;

  function automatic logic [NLEN_W-1:0] len_sat(input int unsigned v);
    return (v > NLEN_MAX) ? NLEN_W'(NLEN_MAX) : NLEN_W'(v);
  endfunction

  function automatic void predict_char(input logic [LEN_W-1:0] clen, input logic eod,
                                       output bit hit, output result_t r);
    int unsigned tsz, first, pos;
    hit = 0;
    r = '0;
    tsz = cur_tsz;
    if (tsz < 1) tsz = 1;
    if (tsz > MAX_TOKEN_CHARS_DEF) tsz = MAX_TOKEN_CHARS_DEF;
    if (!broken) begin
      if (clen == 0) begin
        broken = 1;
      end else if (win_cnt < MAX_TOKEN_CHARS_DEF) begin
        win_len[win_cnt] = clen;
        win_cnt++;
        win_bytes += clen;
        if (win_cnt >= tsz) begin
          r.ngram_offset = win_start[OFS_W-1:0];
          r.ngram_len = len_sat(win_bytes);
          r.is_short = 1'b0;
          r.doc_done = eod;
          hit = 1;
          saw_ngram = 1;
          first = win_len[0];
          pos = win_start + first;
          win_start = (pos > OFS_CAP) ? OFS_CAP : pos;
          win_bytes -= first;
          for (int i = 0; i + 1 < win_cnt; i++) win_len[i] = win_len[i+1];
          win_cnt--;
        end
      end
    end
    if (eod) begin
      if (!hit && cur_short && win_cnt > 0 && !saw_ngram) begin
        r.ngram_offset = win_start[OFS_W-1:0];
        r.ngram_len = len_sat(win_bytes);
        r.is_short = 1'b1;
        r.doc_done = 1'b1;
        hit = 1;
      end
      win_cnt = 0;
      win_bytes = 0;
      win_start = 0;
      saw_ngram = 0;
      broken = 0;
    end
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void flag_mismatch(input string what, input result_t want,
                                        input result_t got);
    errors++;
    if (errors <= 10)
      $display("%s: expected ofs %0d len %0d short %0d done %0d,",
               what, want.ngram_offset, want.ngram_len, want.is_short, want.doc_done,
               " got ofs %0d len %0d short %0d done %0d",
               got.ngram_offset, got.ngram_len, got.is_short, got.doc_done);
  endfunction

  function automatic void add_word(input int clen, input int eod, input exp_kind_t ek,
                                   input int ofs, input int len, input int sh, input int dn);
    row_t w;
    w.kind = ROW_WORD;
    w.idx = '0;
    w.val = '0;
    w.clen = LEN_W'(clen);
    w.eod = eod[0];
    w.ek = ek;
    w.res.ngram_offset = OFS_W'(ofs);
    w.res.ngram_len = NLEN_W'(len);
    w.res.is_short = sh[0];
    w.res.doc_done = dn[0];
    plan.push_back(w);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    row_t w;
    w = '{kind: ROW_CFG, idx: idx, val: val, clen: '0, eod: 1'b0, ek: EXP_NONE, res: '0};
    plan.push_back(w);
  endfunction

  // result side: check and random back-pressure
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      result_t got, want;
      got.ngram_offset = out_tdata[OFS_W-1:0];
      got.ngram_len = out_tdata[OFS_W +: NLEN_W];
      got.is_short = out_tuser;
      got.doc_done = out_tlast;
      results_seen++;
      if (ngram_q.size() == 0) begin
        flag_mismatch("unexpected word", '0, got);
      end else begin
        want = ngram_q.pop_front();
        if (got.ngram_offset !== want.ngram_offset || got.ngram_len !== want.ngram_len ||
            got.is_short !== want.is_short || got.doc_done !== want.doc_done)
          flag_mismatch("mismatch", want, got);
      end
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (!no_idle && $urandom_range(0, 9) == 0) stall_left = pick_idle();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("character_ngram_splitter_test failed");
      $finish;
    end
  end

  task automatic send_word(input logic [LEN_W-1:0] clen, input logic eod);
    int gap;
    gap = (!no_idle && $urandom_range(0, 2) == 0) ? pick_idle() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_DATA_W-LEN_W){1'b0}}, clen};
    in_tlast <= eod;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (eod) docs_ended++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (ngram_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    if (idx == CFG_TOK_CHARS) cur_tsz = val;
    else cur_short = val[0];
  endtask

  task automatic push_predicted(input logic [LEN_W-1:0] clen, input logic eod);
    bit hit;
    result_t r;
    predict_char(clen, eod, hit, r);
    if (hit) ngram_q.push_back(r);
  endtask

  task automatic run_phase(input int n_words);
    logic [LEN_W-1:0] clen;
    logic eod;
    for (int k = 0; k < n_words; k++) begin
      if (doc_left == 0) begin
        doc_noise = ($urandom_range(0, 99) < 15);
        doc_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 28);
      end
      if (doc_noise) begin
        clen = LEN_W'($urandom_range(0, 7));
        eod = ($urandom_range(0, 5) == 0) || (doc_left == 1);
      end else begin
        clen = ($urandom_range(0, 59) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
        eod = (doc_left == 1);
      end
      if (eod) doc_left = 0;
      else doc_left--;
      send_word(clen, eod);
      push_predicted(clen, eod);
      if ($urandom_range(0, 199) == 0) drain_results();
    end
  endtask

  initial begin
    bit hit;
    result_t r;
    foreach (win_len[i]) win_len[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: token size 2, no short tokens
    add_word(7, 0, EXP_NONE, 0, 0, 0, 0);
    add_word(7, 0, EXP_GIVEN, 0, 14, 0, 0);
    add_word(1, 1, EXP_GIVEN, 7, 8, 0, 1);
    add_word(1, 1, EXP_NONE, 0, 0, 0, 0);
    add_word(0, 1, EXP_NONE, 0, 0, 0, 0);
    add_word(3, 0, EXP_MODEL, 0, 0, 0, 0);
    add_word(0, 0, EXP_MODEL, 0, 0, 0, 0);
    add_word(5, 0, EXP_MODEL, 0, 0, 0, 0);
    add_word(4, 1, EXP_NONE, 0, 0, 0, 0);
    // oversized token size acts as ten
    add_cfg(CFG_EMIT_SHORT, 4'd1);
    add_cfg(CFG_TOK_CHARS, 4'd15);
    add_word(2, 0, EXP_NONE, 0, 0, 0, 0);
    add_word(7, 1, EXP_GIVEN, 0, 9, 1, 1);
    for (int i = 0; i < 9; i++) add_word(7, 0, EXP_NONE, 0, 0, 0, 0);
    add_word(7, 0, EXP_GIVEN, 0, 70, 0, 0);
    add_word(7, 1, EXP_GIVEN, 7, 70, 0, 1);
    // zero token size acts as one
    add_cfg(CFG_TOK_CHARS, 4'd0);
    add_word(0, 1, EXP_NONE, 0, 0, 0, 0);
    add_word(1, 1, EXP_GIVEN, 0, 1, 0, 1);
    // break before the end still yields the short token
    add_cfg(CFG_TOK_CHARS, 4'd3);
    add_word(3, 0, EXP_MODEL, 0, 0, 0, 0);
    add_word(0, 0, EXP_MODEL, 0, 0, 0, 0);
    add_word(4, 1, EXP_GIVEN, 0, 3, 1, 1);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_word(plan[i].clen, plan[i].eod);
        predict_char(plan[i].clen, plan[i].eod, hit, r);
        unique case (plan[i].ek)
          EXP_GIVEN: ngram_q.push_back(plan[i].res);
          EXP_MODEL: if (hit) ngram_q.push_back(r);
          EXP_NONE: ;
        endcase
      end
    end

    // one long document of single-character tokens
    write_reg(CFG_TOK_CHARS, 4'd1);
    write_reg(CFG_EMIT_SHORT, 4'd0);
    for (int i = 0; i < LONG_WORDS; i++) begin
      send_word(3'd7, i == LONG_WORDS - 1);
      push_predicted(3'd7, i == LONG_WORDS - 1);
    end

    for (int p = 0; p < 8; p++) begin
      unique case (p)
        0: write_reg(CFG_TOK_CHARS, 4'd10);
        1: write_reg(CFG_TOK_CHARS, 4'd0);
        2: write_reg(CFG_TOK_CHARS, 4'd15);
        3: write_reg(CFG_TOK_CHARS, 4'd1);
        default: write_reg(CFG_TOK_CHARS, 4'($urandom_range(0, 15)));
      endcase
      write_reg(CFG_EMIT_SHORT, (p < 4) ? 4'(p % 2) : 4'($urandom_range(0, 1)));
      no_idle = (p == 3);
      run_phase($urandom_range(190, 230));
    end
    no_idle = 0;

    drain_results();
    repeat (SETTLE * 4) @(posedge clk);
    if (ngram_q.size() != 0) errors++;

    $display("sent %0d words in %0d documents, checked %0d result words",
             words_sent, docs_ended, results_seen);
    $display("%0d register writes across token sizes 0..15, one long document included",
             cfg_writes);
    if (errors == 0) begin
      $display("character_ngram_splitter_test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("character_ngram_splitter_test failed");
    end
    $finish;
  end

endmodule
